FILE: hdl/hnhlr_pkg.sv
// Shared types, constants and the reciprocal table of the hypercube next-hop router.
package hnhlr_pkg;

    localparam int MAX_DIAMETER = 4;
    localparam int MAX_RADIX    = 16;

    localparam int RANK_W      = 16;
    localparam int RADIX_W     = 5;
    localparam int COUNT_W     = 3;
    localparam int LOAD_W      = 32;
    localparam int POS_W       = $clog2(MAX_DIAMETER);
    localparam int PCNT_W      = POS_W + 1;
    localparam int DIG_W       = $clog2(MAX_RADIX);
    localparam int ADDR_W      = POS_W + DIG_W;
    localparam int CNT_DEPTH   = MAX_DIAMETER * MAX_RADIX;
    localparam int WEIGHT_W    = RANK_W + 1;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = RANK_W + RECIP_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = RADIX_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIX  = 2'd0,
        CFG_COUNT  = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [RANK_W-1:0] current_rank;
        logic [RANK_W-1:0] destination_rank;
    } t_req;

    typedef struct packed {
        logic [RANK_W-1:0] next_rank;
        logic              fail;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic dig;
        logic check;
        logic scan;
        logic update;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic enable;
        logic last_digit;
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_sts;

    // floor(2^RECIP_SHIFT / radix); the quotient estimate is low by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] radix);
        logic [RECIP_W-1:0] m;
        case (radix)
            5'd3:    m = 20'd349525;
            5'd4:    m = 20'd262144;
            5'd5:    m = 20'd209715;
            5'd6:    m = 20'd174762;
            5'd7:    m = 20'd149796;
            5'd8:    m = 20'd131072;
            5'd9:    m = 20'd116508;
            5'd10:   m = 20'd104857;
            5'd11:   m = 20'd95325;
            5'd12:   m = 20'd87381;
            5'd13:   m = 20'd80659;
            5'd14:   m = 20'd74898;
            5'd15:   m = 20'd69905;
            5'd16:   m = 20'd65536;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

endpackage

FILE: hdl/hypercube_next_hop_load_router.sv
// Top level of the hypercube next-hop router with load-balanced digit choice.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one request beat, the
// current and destination ranks. Output channel (o_out_valid / i_out_ready /
// o_out_data): one beat per request, the next rank and a fail flag. Config
// writes (i_cfg_we, i_cfg_index, i_cfg_wdata) set radix, digit count and
// enable; write them only while nothing is in flight.
// One request at a time: both ranks are split into digits by a reciprocal
// multiply, a multiply step (S_MUL) and a digit step (S_DIG) per digit, then
// the load counters of the differing positions are read one position per
// cycle. An equal or out-of-range pair skips the counter scan, and a disabled
// router fails without a digit split. The next request can be taken in the
// cycle after the previous result is loaded.
// Reset sets radix 2, two digits, disabled, and clears all load counters at
// once through per-entry valid bits; requests are taken right after reset.
// A stalled receiver holds the result in the output register; the next
// request is still processed, and its result waits until the held beat is
// taken, blocking the input meanwhile.
module hypercube_next_hop_load_router
    import hnhlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rsp                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    hnhlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // config, digit split, counter memory and output register
    hnhlr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hdl/hnhlr_ctrl.sv
// Sequencing state machine of the hypercube next-hop router.
module hnhlr_ctrl
    import hnhlr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL    = 7'b0000010,
        S_DIG    = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE) && i_rst_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    // disabled routing fails at once
                    n_state = i_sts.enable ? S_MUL : S_RESULT;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIG;
            end
            S_DIG: begin
                o_cmd.dig = 1'b1;
                n_state   = i_sts.last_digit ? S_CHECK : S_MUL;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.need_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/hnhlr_dp.sv
// Datapath of the hypercube next-hop router: config, digit split, load counters, output.
module hnhlr_dp
    import hnhlr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_req                  i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_rsp                  o_out_data
);

    typedef struct packed {
        logic [RANK_W-1:0] quot;
        logic [DIG_W-1:0]  digit;
    } t_div;

    // Fix up the reciprocal estimate with one compare and subtract.
    function automatic t_div div_fix(input logic [PROD_W-1:0] prod,
                                     input logic [RANK_W-1:0] num,
                                     input logic [RADIX_W-1:0] radix);
        logic [RANK_W-1:0]         q;
        logic [RANK_W+RADIX_W-1:0] m;
        logic [RANK_W-1:0]         rem;
        logic                      fix;
        t_div                      res;
        q         = prod[PROD_W-1:RECIP_SHIFT];
        m         = q * radix;
        rem       = num - m[RANK_W-1:0];
        fix       = (rem >= RANK_W'(radix));
        res.quot  = q + RANK_W'(fix);
        res.digit = fix ? DIG_W'(rem - RANK_W'(radix)) : DIG_W'(rem);
        return res;
    endfunction

    // Configuration registers
    logic [RADIX_W-1:0] r_cfg_radix;
    logic [COUNT_W-1:0] r_cfg_count;
    logic               r_cfg_enable;
    logic [RADIX_W-1:0] eff_radix;
    logic [PCNT_W-1:0]  eff_count;

    // Per-item registers
    logic [RADIX_W-1:0]  r_radix;
    logic [PCNT_W-1:0]   r_count;
    logic [RANK_W-1:0]   r_cur;
    logic [RANK_W-1:0]   r_dst;
    logic [RANK_W-1:0]   r_qc;
    logic [RANK_W-1:0]   r_qd;
    logic [PROD_W-1:0]   r_prod_c;
    logic [PROD_W-1:0]   r_prod_d;
    logic [PCNT_W-1:0]   r_pos;
    logic [WEIGHT_W-1:0] r_wcur;
    logic [WEIGHT_W-1:0] r_w  [MAX_DIAMETER];
    logic [DIG_W-1:0]    r_cd [MAX_DIAMETER];
    logic [DIG_W-1:0]    r_dd [MAX_DIAMETER];
    logic                r_fail;
    logic                r_same;

    // Scan and update
    logic                r_rd_vld;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic [DIG_W-1:0]    r_rd_cd;
    logic [WEIGHT_W-1:0] r_rd_w;
    logic [LOAD_W-1:0]   r_rd_data;
    logic                r_rd_bit;
    logic                r_found;
    logic [LOAD_W-1:0]   r_top_load;
    logic [ADDR_W-1:0]   r_best_addr;
    logic [DIG_W-1:0]    r_best_cd;
    logic [WEIGHT_W-1:0] r_best_w;
    logic [RANK_W-1:0]   r_delta;

    // Load counter memory with per-entry valid bits
    logic [LOAD_W-1:0]    r_mem [CNT_DEPTH];
    logic [CNT_DEPTH-1:0] r_mem_vld;

    // Output register
    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    logic [PROD_W-1:0]             n_prod_c;
    logic [PROD_W-1:0]             n_prod_d;
    logic [RECIP_W-1:0]            recip_v;
    t_div                          div_c;
    t_div                          div_d;
    logic [WEIGHT_W+RADIX_W-1:0]   w_next;
    logic [POS_W-1:0]              pos_i;
    logic                          pos_live;
    logic                          issue;
    logic                          differ;
    logic [ADDR_W-1:0]             rd_addr;
    logic [LOAD_W-1:0]             load_val;
    logic                          better;
    logic                          out_of_range;
    logic [LOAD_W-1:0]             load_inc;
    logic signed [DIG_W+1:0]       digit_diff;
    logic signed [WEIGHT_W+DIG_W+2:0] delta_full;

    // Clamp the configured geometry
    always_comb begin
        if (r_cfg_radix < RADIX_W'(2)) begin
            eff_radix = RADIX_W'(2);
        end else if (r_cfg_radix > RADIX_W'(MAX_RADIX)) begin
            eff_radix = RADIX_W'(MAX_RADIX);
        end else begin
            eff_radix = r_cfg_radix;
        end
        if (r_cfg_count < COUNT_W'(2)) begin
            eff_count = PCNT_W'(2);
        end else if (r_cfg_count > COUNT_W'(MAX_DIAMETER)) begin
            eff_count = PCNT_W'(MAX_DIAMETER);
        end else begin
            eff_count = PCNT_W'(r_cfg_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_radix  <= RADIX_W'(2);
            r_cfg_count  <= COUNT_W'(2);
            r_cfg_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIX:  r_cfg_radix  <= i_cfg_wdata[RADIX_W-1:0];
                CFG_COUNT:  r_cfg_count  <= i_cfg_wdata[COUNT_W-1:0];
                CFG_ENABLE: r_cfg_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Digit split by reciprocal multiply
    assign recip_v  = recip(r_radix);
    assign n_prod_c = PROD_W'(r_qc) * PROD_W'(recip_v);
    assign n_prod_d = PROD_W'(r_qd) * PROD_W'(recip_v);
    assign div_c    = div_fix(r_prod_c, r_qc, r_radix);
    assign div_d    = div_fix(r_prod_d, r_qd, r_radix);
    assign w_next   = r_wcur * r_radix;

    // Counter scan
    assign pos_i    = r_pos[POS_W-1:0];
    assign pos_live = (r_pos < r_count);
    assign issue    = i_cmd.scan && pos_live;
    assign differ   = (r_cd[pos_i] != r_dd[pos_i]);
    assign rd_addr  = {pos_i, r_dd[pos_i]};
    assign load_val = r_rd_bit ? r_rd_data : '0;
    assign better   = !r_found || (load_val > r_top_load);

    assign out_of_range = (r_qc != '0) || (r_qd != '0);
    assign load_inc     = (&r_top_load) ? r_top_load : r_top_load + 1'b1;
    assign digit_diff   = $signed({2'b00, r_best_addr[DIG_W-1:0]})
                        - $signed({2'b00, r_best_cd});
    assign delta_full   = digit_diff * $signed({1'b0, r_best_w});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix <= eff_radix;
            r_count <= eff_count;
            r_cur   <= i_in_data.current_rank;
            r_dst   <= i_in_data.destination_rank;
            r_qc    <= i_in_data.current_rank;
            r_qd    <= i_in_data.destination_rank;
            r_pos   <= '0;
            r_wcur  <= WEIGHT_W'(1);
            r_fail  <= !r_cfg_enable;
            r_same  <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod_c <= n_prod_c;
            r_prod_d <= n_prod_d;
        end
        if (i_cmd.dig) begin
            r_cd[pos_i] <= div_c.digit;
            r_dd[pos_i] <= div_d.digit;
            r_w[pos_i]  <= r_wcur;
            r_qc        <= div_c.quot;
            r_qd        <= div_d.quot;
            r_wcur      <= w_next[WEIGHT_W-1:0];
            r_pos       <= r_pos + 1'b1;
        end
        if (i_cmd.check) begin
            r_fail <= out_of_range;
            r_same <= (r_cur == r_dst);
            r_pos  <= '0;
        end
        if (issue) begin
            r_rd_addr <= rd_addr;
            r_rd_cd   <= r_cd[pos_i];
            r_rd_w    <= r_w[pos_i];
            r_pos     <= r_pos + 1'b1;
        end
        if (i_cmd.scan && r_rd_vld && better) begin
            r_top_load  <= load_val;
            r_best_addr <= r_rd_addr;
            r_best_cd   <= r_rd_cd;
            r_best_w    <= r_rd_w;
        end
        if (i_cmd.update) begin
            r_delta <= delta_full[RANK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_vld <= issue && differ;
                if (r_rd_vld) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Memory: one registered read port, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_best_addr] <= load_inc;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_bit  <= r_mem_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (i_cmd.update) begin
            r_mem_vld[r_best_addr] <= 1'b1;
        end
    end

    // Result and output register
    always_comb begin
        n_out.fail = r_fail;
        if (r_fail) begin
            n_out.next_rank = '0;
        end else if (r_same) begin
            n_out.next_rank = r_dst;
        end else begin
            n_out.next_rank = r_cur + r_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.enable     = r_cfg_enable;
    assign o_sts.last_digit = (PCNT_W'(r_pos + 1'b1) == r_count);
    assign o_sts.need_scan  = !out_of_range && (r_cur != r_dst);
    assign o_sts.scan_done  = !pos_live && !r_rd_vld;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a beat not yet taken");

    a_update_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> r_found)
        else $error("counter update without a chosen position");

    a_update_not_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> (!r_fail && !r_same))
        else $error("counter update on a failed or finished request");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(i_cmd.scan))
        else $error("counter read pending outside the scan");

endmodule
